@@ hdl/pcf_pkg.sv @@
`default_nettype none
package pcf_pkg;

	// filter selection codes, codes above MODE_SWAP_RB pass the pixel through
	typedef enum logic [3:0] {
		MODE_NONE      = 4'd0,
		MODE_NEGATIVE  = 4'd1,
		MODE_GREY      = 4'd2,
		MODE_SEPIA     = 4'd3,
		MODE_THRESHOLD = 4'd4,
		MODE_INV_RED   = 4'd5,
		MODE_INV_GREEN = 4'd6,
		MODE_INV_BLUE  = 4'd7,
		MODE_SWAP_RB   = 4'd8
	} filter_mode_t;

	// configuration register indexes
	localparam logic REG_FILTER_MODE     = 1'b0;
	localparam logic REG_THRESHOLD_LEVEL = 1'b1;

	localparam logic [7:0] THRESHOLD_RESET = 8'd128;
	localparam logic [7:0] CHAN_MAX        = 8'hFF;

	// one rgba pixel, red in the lowest bits
	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// weights in thousandths
	localparam int LUMA_R_MILLI = 300;
	localparam int LUMA_G_MILLI = 590;
	localparam int LUMA_B_MILLI = 110;
	localparam int SEP_RR_MILLI = 393;
	localparam int SEP_RG_MILLI = 769;
	localparam int SEP_RB_MILLI = 189;
	localparam int SEP_GR_MILLI = 349;
	localparam int SEP_GG_MILLI = 686;
	localparam int SEP_GB_MILLI = 168;
	localparam int SEP_BR_MILLI = 272;
	localparam int SEP_BG_MILLI = 534;
	localparam int SEP_BB_MILLI = 131;

	// fixed point weight, thousandths scaled by 2^frac_bits and rounded
	function automatic int fix_coef(input int frac_bits, input int milli);
		return ((milli << frac_bits) + 500) / 1000;
	endfunction

endpackage
`default_nettype wire

@@ hdl/pcf_weigh.sv @@
`default_nettype none
module pcf_weigh #(
	parameter int FRAC_BITS = 10,
	parameter int COEF_R    = 0,
	parameter int COEF_G    = 0,
	parameter int COEF_B    = 0
) (
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic      [7:0] level
);
	import pcf_pkg::*;

	// three weights below one each, so the scaled sum stays under 2^(8+frac+2)
	localparam int SUM_W = 8 + FRAC_BITS + 2;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] shifted;

	// weighted sum by constant weights
	assign sum = SUM_W'(red) * SUM_W'(COEF_R)
	           + SUM_W'(green) * SUM_W'(COEF_G)
	           + SUM_W'(blue) * SUM_W'(COEF_B);

	assign shifted = sum >> FRAC_BITS;

	// truncate and saturate at full scale
	assign level = (shifted > SUM_W'(CHAN_MAX)) ? CHAN_MAX : shifted[7:0];

endmodule
`default_nettype wire

@@ hdl/pcf_filter.sv @@
`default_nettype none
module pcf_filter #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  wire pcf_pkg::filter_mode_t mode,
	input  wire logic [7:0]            threshold,
	input  wire pcf_pkg::pixel_t       pix_in,
	output pcf_pkg::pixel_t            pix_out
);
	import pcf_pkg::*;

	localparam int F = COEF_FRAC_BITS;

	logic [7:0] luma;
	logic [7:0] sep_red;
	logic [7:0] sep_green;
	logic [7:0] sep_blue;
	logic [7:0] thr_level;

	// brightness
	pcf_weigh #(
		.FRAC_BITS (F),
		.COEF_R    (fix_coef(F, LUMA_R_MILLI)),
		.COEF_G    (fix_coef(F, LUMA_G_MILLI)),
		.COEF_B    (fix_coef(F, LUMA_B_MILLI))
	) u_luma (
		.red   (pix_in.red),
		.green (pix_in.green),
		.blue  (pix_in.blue),
		.level (luma)
	);

	// sepia channels
	pcf_weigh #(
		.FRAC_BITS (F),
		.COEF_R    (fix_coef(F, SEP_RR_MILLI)),
		.COEF_G    (fix_coef(F, SEP_RG_MILLI)),
		.COEF_B    (fix_coef(F, SEP_RB_MILLI))
	) u_sep_red (
		.red   (pix_in.red),
		.green (pix_in.green),
		.blue  (pix_in.blue),
		.level (sep_red)
	);

	pcf_weigh #(
		.FRAC_BITS (F),
		.COEF_R    (fix_coef(F, SEP_GR_MILLI)),
		.COEF_G    (fix_coef(F, SEP_GG_MILLI)),
		.COEF_B    (fix_coef(F, SEP_GB_MILLI))
	) u_sep_green (
		.red   (pix_in.red),
		.green (pix_in.green),
		.blue  (pix_in.blue),
		.level (sep_green)
	);

	pcf_weigh #(
		.FRAC_BITS (F),
		.COEF_R    (fix_coef(F, SEP_BR_MILLI)),
		.COEF_G    (fix_coef(F, SEP_BG_MILLI)),
		.COEF_B    (fix_coef(F, SEP_BB_MILLI))
	) u_sep_blue (
		.red   (pix_in.red),
		.green (pix_in.green),
		.blue  (pix_in.blue),
		.level (sep_blue)
	);

	// black or white against the threshold
	assign thr_level = (luma > threshold) ? CHAN_MAX : 8'd0;

	// mode select
	always_comb begin
		pix_out = pix_in;
		case (mode)
			MODE_NEGATIVE: begin
				pix_out.red   = ~pix_in.red;
				pix_out.green = ~pix_in.green;
				pix_out.blue  = ~pix_in.blue;
			end
			MODE_GREY: begin
				pix_out.red   = luma;
				pix_out.green = luma;
				pix_out.blue  = luma;
			end
			MODE_SEPIA: begin
				pix_out.red   = sep_red;
				pix_out.green = sep_green;
				pix_out.blue  = sep_blue;
			end
			MODE_THRESHOLD: begin
				pix_out.red   = thr_level;
				pix_out.green = thr_level;
				pix_out.blue  = thr_level;
			end
			MODE_INV_RED:   pix_out.red   = ~pix_in.red;
			MODE_INV_GREEN: pix_out.green = ~pix_in.green;
			MODE_INV_BLUE:  pix_out.blue  = ~pix_in.blue;
			MODE_SWAP_RB: begin
				pix_out.red  = pix_in.blue;
				pix_out.blue = pix_in.red;
			end
			default: pix_out = pix_in;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/pixel_color_filter_core.sv @@
// rgba color filter, one pixel per request
// s_axis carries the input pixel, m_axis the filtered pixel, both packed as
// red in bits 7:0, green 15:8, blue 23:16, alpha 31:24.
// cfg_we with cfg_index 0 writes filter_mode (cfg_wdata[3:0]), index 1 writes
// threshold_level; write only while no pixel is in flight.
// modes: 0 pass, 1 negative, 2 grey, 3 sepia, 4 threshold, 5..7 invert
// red/green/blue, 8 swap red and blue, 9..15 pass; alpha is never changed.
// the request is accepted into the input register, then passes the filter
// logic into the output register, from which m_axis presents the result.
// throughput is one pixel per cycle unless m_axis stalls; both registers hold
// their own valid bit, so an empty slot is refilled even while the output waits.
// when m_axis_tready is low the output register holds, the input register
// fills behind it, and s_axis_tready drops once both are full.
// reset clears both valid bits, sets filter_mode to pass-through and
// threshold_level to 128.
`default_nettype none
module pixel_color_filter_core #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input pixel
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
	// filtered pixel
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_wdata
);
	import pcf_pkg::*;

	filter_mode_t mode_q;
	logic [7:0]   threshold_q;

	logic   valid_s1;
	pixel_t pix_s1;
	logic   valid_s2;
	pixel_t pix_s2;
	pixel_t pix_filt;
	logic   load_s1;
	logic   load_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MODE:     mode_q      <= filter_mode_t'(cfg_wdata[3:0]);
				REG_THRESHOLD_LEVEL: threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables
	assign load_s2       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pix_s1 <= pixel_t'(s_axis_tdata);
		end
	end

	// filter logic
	pcf_filter #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_filter (
		.mode      (mode_q),
		.threshold (threshold_q),
		.pix_in    (pix_s1),
		.pix_out   (pix_filt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			pix_s2 <= pix_filt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = pix_s2;

endmodule
`default_nettype wire

@@ tb/sv/pcf_pixel_scoreboard.sv @@
module pcf_pixel_scoreboard #(
	parameter int COEF_FRAC_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,    // red_in, green_in, blue_in, alpha_in
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,    // red_out, green_out, blue_out, alpha_out
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcf_pkg::*;

	// shadow copy of the configuration registers
	logic [3:0] cur_mode;
	logic [7:0] cur_level;

	// filtered pixels still owed by the block, oldest first
	pixel_t owed_pixels[$];

	// weight in thousandths as unsigned fixed point, rounded to nearest
	function automatic int scaled_weight(input int milli);
		int scaled;
		scaled = milli * (1 << COEF_FRAC_BITS) + 500;
		return scaled / 1000;
	endfunction

	// weighted channel sum, truncated and clipped to a channel value
	function automatic logic [7:0] mix_channels(input pixel_t p, input int wr,
			input int wg, input int wb);
		int acc;
		acc = scaled_weight(wr) * int'(p.red) + scaled_weight(wg) * int'(p.green)
			+ scaled_weight(wb) * int'(p.blue);
		acc = acc >> COEF_FRAC_BITS;
		return (acc > 255) ? CHAN_MAX : acc[7:0];
	endfunction

	// filtered pixel for the current mode and threshold
	function automatic pixel_t filter_pixel(input pixel_t p, input logic [3:0] mode,
			input logic [7:0] level);
		pixel_t q;
		logic [7:0] luma;
		q = p;
		luma = mix_channels(p, LUMA_R_MILLI, LUMA_G_MILLI, LUMA_B_MILLI);
		case (mode)
			MODE_NEGATIVE: begin
				q.red = CHAN_MAX - p.red;
				q.green = CHAN_MAX - p.green;
				q.blue = CHAN_MAX - p.blue;
			end
			MODE_GREY: begin
				q.red = luma;
				q.green = luma;
				q.blue = luma;
			end
			MODE_SEPIA: begin
				q.red = mix_channels(p, SEP_RR_MILLI, SEP_RG_MILLI, SEP_RB_MILLI);
				q.green = mix_channels(p, SEP_GR_MILLI, SEP_GG_MILLI, SEP_GB_MILLI);
				q.blue = mix_channels(p, SEP_BR_MILLI, SEP_BG_MILLI, SEP_BB_MILLI);
			end
			MODE_THRESHOLD: begin
				q.red = (luma > level) ? CHAN_MAX : 8'd0;
				q.green = q.red;
				q.blue = q.red;
			end
			MODE_INV_RED: q.red = CHAN_MAX - p.red;
			MODE_INV_GREEN: q.green = CHAN_MAX - p.green;
			MODE_INV_BLUE: q.blue = CHAN_MAX - p.blue;
			MODE_SWAP_RB: begin
				q.red = p.blue;
				q.blue = p.red;
			end
			default: ;
		endcase
		return q;
	endfunction

	// report one channel that differs
	task automatic note_mismatch(input string chan, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: %s expected %0d actual %0d", $realtime, chan, want, got);
		fail_count++;
	endtask

	// compare results first, then queue new requests, then apply writes
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			cur_mode = MODE_NONE;
			cur_level = THRESHOLD_RESET;
			owed_pixels.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (owed_pixels.size() == 0) begin
					$display("%0t: expected no pixel, actual %h", $realtime, got);
					fail_count++;
				end else begin
					want = owed_pixels.pop_front();
					if (got.red !== want.red) note_mismatch("red", want.red, got.red);
					if (got.green !== want.green)
						note_mismatch("green", want.green, got.green);
					if (got.blue !== want.blue) note_mismatch("blue", want.blue, got.blue);
					if (got.alpha !== want.alpha)
						note_mismatch("alpha", want.alpha, got.alpha);
				end
			end
			if (s_tvalid && s_tready)
				owed_pixels.push_back(filter_pixel(pixel_t'(s_tdata), cur_mode, cur_level));
			if (cfg_we) begin
				if (cfg_index == REG_FILTER_MODE)
					cur_mode = cfg_wdata[3:0];
				else
					cur_level = cfg_wdata;
			end
			pending_count = owed_pixels.size();
		end
	end

endmodule

@@ tb/sv/pixel_color_filter_core_tb.sv @@
module pixel_color_filter_core_tb;
	import pcf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         RUN_LIMIT     = 400000;
	localparam int         PIPE_SETTLE   = 4;
	localparam int         BLOCK_COUNT   = 24;
	localparam int         BLOCK_PIXELS  = 80;
	localparam int         LONG_HOLD     = 64;
	localparam logic [3:0] MODE_SPARE_TOP = 4'hF;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;

	int fail_count;
	int pending_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_left;

	pixel_color_filter_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	pcf_pixel_scoreboard i_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_axis_tvalid),
		.s_tready     (s_axis_tready),
		.s_tdata      (s_axis_tdata),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver side: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			m_axis_tready = 1'b0;
			hold_off_left--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// random channel value, extremes now and then
	function automatic logic [7:0] rand_chan();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? CHAN_MAX : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.red = rand_chan();
		p.green = rand_chan();
		p.blue = rand_chan();
		p.alpha = rand_chan();
		return p;
	endfunction

	// offer one pixel request, entered and left at a falling edge
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = p;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// wait until every filtered pixel is back and the pipeline is empty
	task automatic drain_pipe();
		s_axis_tvalid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// new filter setting, upper write bits of the mode register are junk
	task automatic set_filter(input logic [3:0] mode, input logic [7:0] level);
		drain_pipe();
		write_reg(REG_FILTER_MODE, {4'($urandom_range(15)), mode});
		write_reg(REG_THRESHOLD_LEVEL, level);
	endtask

	// stimulus
	initial begin
		logic [3:0] directed_modes [10];
		logic [3:0] mode;
		logic [7:0] level;
		int         phase;
		int         idle_table [4];
		int         stall_table [4];

		directed_modes = '{MODE_NONE, MODE_NEGATIVE, MODE_GREY, MODE_SEPIA,
			MODE_THRESHOLD, MODE_INV_RED, MODE_INV_GREEN, MODE_INV_BLUE,
			MODE_SWAP_RB, MODE_SPARE_TOP};
		idle_table = '{0, 67, 0, 29};
		stall_table = '{0, 0, 67, 29};

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FILTER_MODE;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset setting first, then modes 0 to 8 and 15 on black, white and mixed pixels
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		foreach (directed_modes[i]) begin
			set_filter(directed_modes[i], THRESHOLD_RESET);
			send_pixel(32'h0000_0000);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'h5A10_80F0);
		end
		// threshold at the boundary: grey level equal to the threshold gives black
		set_filter(MODE_THRESHOLD, THRESHOLD_RESET);
		send_pixel({8'h33, 8'd128, 8'd128, 8'd128});
		send_pixel({8'hCC, 8'd129, 8'd129, 8'd129});

		// random blocks, each with its own setting and idling phase
		for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
			mode = (blk < 16) ? 4'(blk) : 4'($urandom_range(15));
			if (blk == 20 || blk == 21) mode = MODE_THRESHOLD;
			if (blk == 4)
				level = 8'd0;
			else if (blk == 20)
				level = CHAN_MAX;
			else
				level = 8'($urandom_range(255));
			set_filter(mode, level);
			phase = blk % 4;
			send_idle_pct = idle_table[phase];
			recv_stall_pct = stall_table[phase];
			// back pressure: output held off while input keeps coming
			if (blk == 0 || blk == 8) hold_off_left = LONG_HOLD;
			for (int n = 0; n < BLOCK_PIXELS; n++)
				send_pixel(rand_pixel());
		end

		drain_pipe();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/pcf_pkg.sv
hdl/pcf_weigh.sv
hdl/pcf_filter.sv
hdl/pixel_color_filter_core.sv
tb/sv/pcf_pixel_scoreboard.sv
tb/sv/pixel_color_filter_core_tb.sv
